[sv/pfne_pkg.sv]
// Shared widths, limits and saturating helpers for the normal-equation accumulator.
// Standalone; used by poly_fit_normal_equation_accumulator_top.
`default_nettype none

package pfne_pkg;

  localparam int SMP_W  = 16;              // Q1.15 sample width
  localparam int P_W    = 17;              // running power, holds 1.0 exactly
  localparam int PROD_W = P_W + SMP_W;     // multiplier product width
  localparam int ACC_W  = 48;              // Q.30 accumulator width
  localparam int IDX_W  = 5;               // emitted exponent field
  localparam int CFG_W  = 4;               // degree register width
  localparam int DEG_RESET = 2;

  localparam logic signed [P_W-1:0] P_ONE = 17'sh08000;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [P_W-1:0]   pow_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // Add with saturation to the signed accumulator range.
  function automatic acc_t sat_add(input acc_t acc, input acc_t term);
    logic signed [ACC_W:0] s;
    acc_t r;
    s = {acc[ACC_W-1], acc} + {term[ACC_W-1], term};
    if (s[ACC_W] != s[ACC_W-1]) begin
      r = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      r = s[ACC_W-1:0];
    end
    return r;
  endfunction

  // Floor a Q3.30 product back to Q1.15 and clamp to the sample range.
  function automatic pow_t q15_clamp(input prod_t prod);
    logic signed [PROD_W-16:0] f;
    pow_t r;
    f = prod[PROD_W-1:15];
    if (f > 18'sd32767) begin
      r = 17'sd32767;
    end else if (f < -18'sd32768) begin
      r = -17'sd32768;
    end else begin
      r = f[P_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/poly_fit_normal_equation_accumulator_top.sv]
// Polynomial least-squares normal-equation accumulator, top level.
// Depends on pfne_pkg for widths, saturating add and Q1.15 clamp.
`default_nettype none

// Usage
//   Input channel: in_valid / in_stall carry one sample point (x_value, y_value,
//   last_point) per transfer. in_stall is high while a point is being worked.
//   Each point is worked through all exponents before the next transfer: one
//   shared 17x16 multiplier forms p*y and then p*x for every exponent, and
//   each sum is a read-modify-write of its memory.
//   Output channel: out_valid / out_stall carry one sum per transfer. After
//   the point flagged last, 2d+1 power sums (kind 0, index 0..2d) then d+1
//   cross sums (kind 1, index 0..d) follow; the final cross sum carries
//   last_result. A stalled result holds in the output register and the
//   emission sequencer waits behind it. The input reopens as soon as the
//   last sum is loaded, so a new set can start while that sum still waits
//   for its transfer.
//   Configuration: cfg_write_en / cfg_write_data write the degree; 0 acts as
//   1 and values above MAX_DEGREE as MAX_DEGREE. The degree only sets how
//   many sums are emitted and is read when emission starts.
//   Reset (rst, synchronous): degree returns to 2, all sums read as zero
//   (per-entry valid bits are cleared), any output is dropped.
module poly_fit_normal_equation_accumulator_top #(
  parameter int MAX_DEGREE = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write_en,
  input  wire logic [pfne_pkg::CFG_W-1:0]         cfg_write_data,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [pfne_pkg::SMP_W-1:0]  x_value,
  input  wire logic signed [pfne_pkg::SMP_W-1:0]  y_value,
  input  wire logic                               last_point,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    sum_kind,
  output logic [pfne_pkg::IDX_W-1:0]              sum_index,
  output logic signed [pfne_pkg::ACC_W-1:0]       sum_value,
  output logic                                    last_result
);

  localparam int NPOW   = 2 * MAX_DEGREE + 1;
  localparam int NCROSS = MAX_DEGREE + 1;
  localparam int PIDX_W = $clog2(NPOW);
  localparam int CIDX_W = $clog2(NCROSS);
  localparam int DEG_W  = $clog2(MAX_DEGREE + 1);
  localparam int EW     = PIDX_W + 2;
  localparam int CFG_W  = pfne_pkg::CFG_W;
  localparam int CMP_W  = (DEG_W > CFG_W) ? DEG_W : CFG_W;
  localparam int IW     = pfne_pkg::IDX_W;
  localparam int SW     = pfne_pkg::SMP_W;

  localparam logic [PIDX_W-1:0] K_LAST       = PIDX_W'(NPOW - 1);
  localparam logic [PIDX_W-1:0] K_CROSS_LAST = PIDX_W'(MAX_DEGREE);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_ACC,
    S_NEXT,
    S_EMIT_RD,
    S_EMIT_OUT
  } state_t;

  state_t state;

  // Configuration and per-point operands.
  logic [CFG_W-1:0]        degree;
  logic [DEG_W-1:0]        deg_eff;
  logic [DEG_W-1:0]        deg_eff_next;
  logic signed [SW-1:0]    x_reg;
  logic signed [SW-1:0]    y_reg;
  logic                    last_reg;

  // Sequencer.
  logic [PIDX_W-1:0]       k;
  logic [PIDX_W-1:0]       e_idx;
  logic                    emit_cross;
  pfne_pkg::pow_t          p;
  pfne_pkg::prod_t         prod;
  logic signed [SW-1:0]    mul_b;

  // Sum stores.
  pfne_pkg::acc_t          pow_mem   [NPOW];
  pfne_pkg::acc_t          cross_mem [NCROSS];
  pfne_pkg::acc_t          pow_rd;
  pfne_pkg::acc_t          cross_rd;
  logic [NPOW-1:0]         pow_vld;
  logic [NCROSS-1:0]       cross_vld;
  logic                    pow_hit;
  logic                    cross_hit;
  logic [PIDX_W-1:0]       pow_raddr;
  logic [CIDX_W-1:0]       cross_raddr;
  logic                    pow_we;
  logic                    cross_we;
  pfne_pkg::acc_t          pow_new;
  pfne_pkg::acc_t          cross_new;
  pfne_pkg::acc_t          pow_cur;
  pfne_pkg::acc_t          cross_cur;
  pfne_pkg::acc_t          pow_term;
  pfne_pkg::acc_t          cross_term;

  // Emission control.
  logic                    out_free;
  logic                    out_load;
  logic                    emit_pow_end;
  logic                    emit_cross_end;
  logic [CMP_W-1:0]        deg_wide;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign out_load = (state == S_EMIT_OUT) && out_free;

  // Clamp the degree register into 1..MAX_DEGREE.
  always_comb begin
    deg_wide = CMP_W'(degree);
    if (degree == '0) begin
      deg_eff_next = DEG_W'(1);
    end else if (deg_wide > CMP_W'(MAX_DEGREE)) begin
      deg_eff_next = DEG_W'(MAX_DEGREE);
    end else begin
      deg_eff_next = deg_wide[DEG_W-1:0];
    end
  end

  assign emit_pow_end   = (EW'(e_idx) == EW'({deg_eff, 1'b0}));
  assign emit_cross_end = (EW'(e_idx) == EW'(deg_eff));

  // Shared multiplier: p*y while reading the sums, p*x while writing them.
  assign mul_b = (state == S_RD) ? y_reg : x_reg;

  always_ff @(posedge clk) begin
    prod <= p * mul_b;
  end

  // Read addresses: the exponent under work, or the sum being emitted.
  assign pow_raddr   = (state == S_RD) ? k : e_idx;
  assign cross_raddr = (state == S_RD) ? k[CIDX_W-1:0] : e_idx[CIDX_W-1:0];

  // Accumulate: a never-written (or cleared) entry reads as zero.
  assign pow_cur    = pow_hit ? pow_rd : '0;
  assign cross_cur  = cross_hit ? cross_rd : '0;
  assign pow_term   = {{(pfne_pkg::ACC_W - pfne_pkg::P_W - 15){p[pfne_pkg::P_W-1]}},
                       p, 15'b0};
  assign cross_term = {{(pfne_pkg::ACC_W - pfne_pkg::PROD_W){prod[pfne_pkg::PROD_W-1]}},
                       prod};
  assign pow_new    = pfne_pkg::sat_add(pow_cur, pow_term);
  assign cross_new  = pfne_pkg::sat_add(cross_cur, cross_term);
  assign pow_we     = (state == S_ACC);
  assign cross_we   = (state == S_ACC) && (k <= K_CROSS_LAST);

  always_ff @(posedge clk) begin
    if (pow_we) begin
      pow_mem[k] <= pow_new;
    end
    pow_rd <= pow_mem[pow_raddr];
  end

  always_ff @(posedge clk) begin
    if (cross_we) begin
      cross_mem[k[CIDX_W-1:0]] <= cross_new;
    end
    cross_rd <= cross_mem[cross_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      degree     <= CFG_W'(pfne_pkg::DEG_RESET);
      pow_vld    <= '0;
      cross_vld  <= '0;
      out_valid  <= 1'b0;
      k          <= '0;
      e_idx      <= '0;
      emit_cross <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        degree <= cfg_write_data;
      end

      // Load the next result, or drop the held one once it transfers.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      if (state == S_RD || state == S_EMIT_RD) begin
        pow_hit   <= pow_vld[pow_raddr];
        cross_hit <= cross_vld[cross_raddr];
      end

      if (pow_we) begin
        pow_vld[k] <= 1'b1;
      end
      if (cross_we) begin
        cross_vld[k[CIDX_W-1:0]] <= 1'b1;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            x_reg    <= x_value;
            y_reg    <= y_value;
            last_reg <= last_point;
            p        <= pfne_pkg::P_ONE;
            k        <= '0;
            state    <= S_RD;
          end
        end
        S_RD: begin
          state <= S_ACC;
        end
        S_ACC: begin
          if (k == K_LAST) begin
            if (last_reg) begin
              deg_eff    <= deg_eff_next;
              e_idx      <= '0;
              emit_cross <= 1'b0;
              state      <= S_EMIT_RD;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          p     <= pfne_pkg::q15_clamp(prod);
          k     <= k + 1'b1;
          state <= S_RD;
        end
        S_EMIT_RD: begin
          state <= S_EMIT_OUT;
        end
        S_EMIT_OUT: begin
          if (out_free) begin
            sum_kind    <= emit_cross;
            sum_index   <= IW'(e_idx);
            sum_value   <= emit_cross ? cross_cur : pow_cur;
            last_result <= emit_cross && emit_cross_end;
            if (!emit_cross) begin
              if (emit_pow_end) begin
                emit_cross <= 1'b1;
                e_idx      <= '0;
              end else begin
                e_idx <= e_idx + 1'b1;
              end
              state <= S_EMIT_RD;
            end else if (emit_cross_end) begin
              // Set complete: every sum reads as zero again.
              pow_vld   <= '0;
              cross_vld <= '0;
              state     <= S_IDLE;
            end else begin
              e_idx <= e_idx + 1'b1;
              state <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_load_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_EMIT_OUT))
    else $error("result loaded outside emission");

  a_last_is_cross: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_result) |-> sum_kind)
    else $error("last_result on a power sum");

  a_cleared_after_set: assert property (@(posedge clk) disable iff (rst)
    (($past(state) == S_EMIT_OUT) && (state == S_IDLE)) |->
      ((pow_vld == '0) && (cross_vld == '0)))
    else $error("sums not cleared after emission");

  a_power_in_range: assert property (@(posedge clk) disable iff (rst)
    ((state == S_RD) && (k != '0)) |->
      ((p <= 17'sd32767) && (p >= -17'sd32768)))
    else $error("running power outside Q1.15");
`endif

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for poly_fit_normal_equation_accumulator_top: random and directed sample
// points, a built-in power/cross sum predictor and an in-order result scoreboard.
// Depends on pfne_pkg and the accumulator RTL only.

module tb_top;

  localparam int SMP_W = pfne_pkg::SMP_W;
  localparam int IDX_W = pfne_pkg::IDX_W;
  localparam int CFG_W = pfne_pkg::CFG_W;

  typedef pfne_pkg::acc_t acc_t;

  localparam int MAX_DEG   = 8;
  localparam int NUM_POW   = 2 * MAX_DEG + 1;
  localparam int NUM_CROSS = MAX_DEG + 1;

  // Sum kinds as carried on sum_kind
  localparam logic KIND_POWER = 1'b0;
  localparam logic KIND_CROSS = 1'b1;

  localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam longint Q15_ONE = 32768;

  // Cycles to let pass before a degree write or the end of the run
  localparam int SETTLE_CYCLES = 200;

  typedef struct packed {
    logic signed [SMP_W-1:0] x;
    logic signed [SMP_W-1:0] y;
    logic                    last;
  } point_t;

  typedef struct packed {
    logic             kind;
    logic [IDX_W-1:0] index;
    acc_t             value;
    logic             last;
  } sum_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                    cfg_write_en   = 1'b0;
  logic [CFG_W-1:0]        cfg_write_data = '0;
  logic                    in_valid       = 1'b0;
  logic                    in_stall;
  logic signed [SMP_W-1:0] x_value        = '0;
  logic signed [SMP_W-1:0] y_value        = '0;
  logic                    last_point     = 1'b0;
  logic                    out_valid;
  logic                    out_stall      = 1'b0;
  logic                    sum_kind;
  logic [IDX_W-1:0]        sum_index;
  acc_t                    sum_value;
  logic                    last_result;

  poly_fit_normal_equation_accumulator_top #(
    .MAX_DEGREE(MAX_DEG)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .x_value       (x_value),
    .y_value       (y_value),
    .last_point    (last_point),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sum_kind      (sum_kind),
    .sum_index     (sum_index),
    .sum_value     (sum_value),
    .last_result   (last_result)
  );

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard limit: far above the slowest legal run (~330 points plus a few thousand
  // stalled sum transfers)
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the sums and the degree register
  // ---------------------------------------------------------------------------
  acc_t             power_acc [NUM_POW];
  acc_t             cross_acc [NUM_CROSS];
  logic [CFG_W-1:0] degree_setting = CFG_W'(pfne_pkg::DEG_RESET);

  sum_rec_t expected_sums [$];   // sums still owed by the block, oldest first
  point_t   pending_points [$];  // points not yet offered to the block
  point_t   next_point;
  int       points_in_flight = 0;
  int       error_count = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;

  initial begin
    for (int k = 0; k < NUM_POW; k++) power_acc[k] = '0;
    for (int k = 0; k < NUM_CROSS; k++) cross_acc[k] = '0;
  end

  function automatic acc_t clamp48(input longint v);
    if (v > ACC_HI) return acc_t'(ACC_HI);
    if (v < ACC_LO) return acc_t'(ACC_LO);
    return acc_t'(v);
  endfunction

  // Fold one accepted point into the sums; on a last point queue the sums
  // the block must emit and clear them.
  function automatic void fold_point(input logic signed [SMP_W-1:0] x,
                                     input logic signed [SMP_W-1:0] y,
                                     input logic last);
    longint pw;
    longint xs;
    longint ys;
    int     eff_deg;
    sum_rec_t rec;
    pw = Q15_ONE;
    xs = x;
    ys = y;
    for (int k = 0; k < NUM_POW; k++) begin
      if (k > 0) begin
        // floor to Q1.15, then clamp: only (-1.0)^even overshoots
        pw = (pw * xs) >>> 15;
        if (pw > 32767) pw = 32767;
        if (pw < -32768) pw = -32768;
      end
      power_acc[k] = clamp48(longint'(power_acc[k]) + pw * Q15_ONE);
      if (k < NUM_CROSS) cross_acc[k] = clamp48(longint'(cross_acc[k]) + pw * ys);
    end
    if (!last) return;

    // Degree 0 acts as 1, anything above the maximum as the maximum
    eff_deg = int'(degree_setting);
    if (eff_deg < 1) eff_deg = 1;
    if (eff_deg > MAX_DEG) eff_deg = MAX_DEG;

    for (int k = 0; k <= 2 * eff_deg; k++) begin
      rec.kind  = KIND_POWER;
      rec.index = IDX_W'(k);
      rec.value = power_acc[k];
      rec.last  = 1'b0;
      expected_sums.push_back(rec);
    end
    for (int k = 0; k <= eff_deg; k++) begin
      rec.kind  = KIND_CROSS;
      rec.index = IDX_W'(k);
      rec.value = cross_acc[k];
      rec.last  = (k == eff_deg);
      expected_sums.push_back(rec);
    end
    for (int k = 0; k < NUM_POW; k++) power_acc[k] = '0;
    for (int k = 0; k < NUM_CROSS; k++) cross_acc[k] = '0;
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: offer queued points; hold the payload while stalled
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      // A transfer happened at this edge: predict from the payload just taken
      if (in_valid) begin
        fold_point(x_value, y_value, last_point);
        points_in_flight--;
      end
      // Advance to the next point unless this cycle idles
      if (pending_points.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_point = pending_points.pop_front();
        in_valid   <= 1'b1;
        x_value    <= next_point.x;
        y_value    <= next_point.y;
        last_point <= next_point.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor: check each sum transfer against the oldest expectation,
  // and stall at random
  // ---------------------------------------------------------------------------
  task automatic report_field(input string name, input longint want, input longint got);
    error_count++;
    $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
  endtask

  sum_rec_t owed;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_sums.size() == 0) begin
          error_count++;
          $display("%0t: unexpected sum, expected none actual kind %0d index %0d value %0d",
                   $time, sum_kind, sum_index, sum_value);
        end else begin
          owed = expected_sums.pop_front();
          if (sum_kind !== owed.kind) report_field("sum_kind", owed.kind, sum_kind);
          if (sum_index !== owed.index) report_field("sum_index", owed.index, sum_index);
          if (sum_value !== owed.value) report_field("sum_value", owed.value, sum_value);
          if (last_result !== owed.last)
            report_field("last_result", owed.last, last_result);
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic add_point(input int x, input int y, input logic last);
    point_t pt;
    pt.x    = SMP_W'(x);
    pt.y    = SMP_W'(y);
    pt.last = last;
    pending_points.push_back(pt);
    points_in_flight++;
  endtask

  // Bias toward +-1.0 so high powers stay large; keep plenty of full-range values
  function automatic int pick_sample();
    int sel;
    sel = $urandom_range(9);
    if (sel < 5) return int'($urandom_range(65535)) - 32768;
    if (sel == 5) return -32768 + int'($urandom_range(600));
    if (sel == 6) return 32767 - int'($urandom_range(600));
    case ($urandom_range(4))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  // One data set of random points; mostly short, now and then long
  task automatic add_random_set(output int count);
    count = ($urandom_range(9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 6);
    for (int i = 0; i < count; i++)
      add_point(pick_sample(), pick_sample(), i == count - 1);
  endtask

  // Block is idle: every point taken and worked, every sum transferred
  task automatic wait_drained();
    while (points_in_flight != 0 || expected_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_degree(input int value);
    @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= CFG_W'(value);
    degree_setting = CFG_W'(value);
    @(posedge clk);
    cfg_write_en   <= 1'b0;
  endtask

  task automatic random_phase(input int degree, input int quota);
    int added;
    int n;
    write_degree(degree);
    added = 0;
    while (added < quota) begin
      add_random_set(n);
      added += n;
    end
    wait_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part and first random part: sender idles lightly, receiver heavily
    send_idle_pct = 28;
    recv_idle_pct = 64;

    // Reset degree, single-point set at x = 0
    add_point(0, 0, 1'b1);
    // Field extremes
    add_point(-32768, 32767, 1'b0);
    add_point(32767, -32768, 1'b1);
    wait_drained();

    // Degree 0 acts as 1; x = -1.0 saturates every even power above zero
    write_degree(0);
    add_point(-32768, -32768, 1'b1);
    wait_drained();

    // Degree above the maximum acts as the maximum
    write_degree(15);
    add_point(-32768, 32767, 1'b0);
    add_point(-1, 1, 1'b0);
    add_point(1, -1, 1'b1);
    wait_drained();

    // Degree change in the middle of a set: only the emitted count moves
    write_degree(MAX_DEG);
    add_point(16384, 16384, 1'b0);
    add_point(-16384, 12345, 1'b0);
    wait_drained();
    write_degree(1);
    add_point(-32768, -32768, 1'b1);
    wait_drained();

    // Alternating bit patterns
    write_degree(3);
    add_point(16'sh5555, -21846, 1'b0);
    add_point(-21846, 16'sh5555, 1'b0);
    add_point(16'sh7FFF, 0, 1'b1);
    wait_drained();

    random_phase(1, 26);
    random_phase(MAX_DEG, 26);
    random_phase(5, 26);

    // Swap the pressure
    send_idle_pct = 64;
    recv_idle_pct = 28;
    random_phase(15, 26);
    random_phase(0, 26);
    random_phase(4, 26);

    // Full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(2, 26);
    random_phase(7, 26);
    random_phase(MAX_DEG, 26);

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
